// ----- src/macd_pkg.sv -----
// macd_pkg: widths, codes, sequencer states and helper functions of the MACD filter
// used by macd_alu and macd_ema_filter; depends on nothing else
package macd_pkg;

  localparam int unsigned PRICE_W     = 32;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned ACC_W       = 40;
  localparam int unsigned ALPHA_BITS  = 24;
  localparam int unsigned ALPHA_W     = ALPHA_BITS + 1;
  localparam int unsigned DIFF_W      = PRICE_W + 1;
  localparam int unsigned PROD_W      = DIFF_W + ALPHA_W + 1;
  localparam int unsigned DIV_W       = ACC_W + 1;
  localparam int unsigned DEN_W       = LEN_W + 1;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_LENGTH  = 255;
  localparam int unsigned COUNT_TOP   = (1 << CNT_W) - 1;

  localparam logic [LEN_W-1:0] FAST_RESET   = LEN_W'(12);
  localparam logic [LEN_W-1:0] SLOW_RESET   = LEN_W'(26);
  localparam logic [LEN_W-1:0] SIGNAL_RESET = LEN_W'(9);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FAST   = 2'd0,
    REG_SLOW   = 2'd1,
    REG_SIGNAL = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CH_FAST   = 2'd0,
    CH_SLOW   = 2'd1,
    CH_SIGNAL = 2'd2
  } chan_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ALPHA,
    ST_ALPHA_WAIT,
    ST_STEP,
    ST_SEED_DIV,
    ST_SEED_WAIT,
    ST_UPD,
    ST_MACD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
  } alu_ctrl_t;

  typedef struct packed {
    logic div_done;
    logic rem_nz;
  } alu_stat_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] l);
    logic [LEN_W-1:0] r;
    r = l;
    if (r == '0) begin
      r = LEN_W'(1);
    end
    if ({1'b0, r} > (LEN_W+1)'(MAX_LENGTH)) begin
      r = LEN_W'(MAX_LENGTH);
    end
    return r;
  endfunction

  function automatic logic [PRICE_W-1:0] sat32(input logic signed [ACC_W:0] v);
    logic [PRICE_W-1:0] r;
    if (v > $signed({{(ACC_W-PRICE_W+2){1'b0}}, {(PRICE_W-1){1'b1}}})) begin
      r = {1'b0, {(PRICE_W-1){1'b1}}};
    end else if (v < $signed({{(ACC_W-PRICE_W+2){1'b1}}, {(PRICE_W-1){1'b0}}})) begin
      r = {1'b1, {(PRICE_W-1){1'b0}}};
    end else begin
      r = v[PRICE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/macd_alu.sv -----
// macd_alu: shared arithmetic unit, registered multiplier and
// bit-serial restoring divider; depends on macd_pkg
module macd_alu import macd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  alu_ctrl_t                 ctrl_i,
  input  logic signed [DIFF_W-1:0]  mul_a_i,
  input  logic [ALPHA_W-1:0]        mul_b_i,
  input  logic [DIV_W-1:0]          div_num_i,
  input  logic [DEN_W-1:0]          div_den_i,
  output logic signed [PROD_W-1:0]  prod_o,
  output logic [DIV_W-1:0]          quot_o,
  output alu_stat_t                 stat_o
);

  logic signed [PROD_W-1:0] prod_q;
  logic [DIV_W-1:0]         dv_q, dv_d;
  logic [DEN_W-1:0]         rem_q, rem_d, den_q;
  logic [DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic                     done_q, done_d;
  logic [DEN_W:0]           rem_sh;
  logic                     ge;

  assign rem_sh = {rem_q, dv_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    dv_d   = dv_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.div_start) begin
      dv_d  = div_num_i;
      rem_d = '0;
      cnt_d = DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      dv_d   = {dv_q[DIV_W-2:0], ge};
      cnt_d  = cnt_q - DIV_CNT_W'(1);
      done_d = (cnt_q == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q  <= dv_d;
    rem_q <= rem_d;
    if (ctrl_i.div_start) begin
      den_q <= div_den_i;
    end
    if (ctrl_i.mul_start) begin
      prod_q <= mul_a_i * $signed({1'b0, mul_b_i});
    end
  end

  assign prod_o          = prod_q;
  assign quot_o          = dv_q;
  assign stat_o.div_done = done_q;
  assign stat_o.rem_nz   = rem_q != '0;

endmodule

// ----- src/macd_ema_filter.sv -----
// macd_ema_filter: streaming MACD with fast, slow and signal exponential averages
// sequencer and state on top of the shared unit macd_alu; depends on macd_pkg
//
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   close_price_i, start_of_series_i
// out      source     out_valid_o / out_stall_i macd_value_o, macd_valid_o,
//                                               signal_value_o, signal_valid_o
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// an item that updates all three averages passes from accept to result with one state
// per step of the sequencer and one multiply each through the shared unit; the next item
// is taken only once the sequencer is back in idle; an average still filling its seed
// sum skips its update state
// an item that seeds an average also runs the serial divider for each average it seeds
// after reset or a length write, the next item first rebuilds alpha for each stale length
// the result sits in an output register; the next item is taken meanwhile and
// waits in its last state only while that register is still stalled
module macd_ema_filter import macd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PRICE_W-1:0]   close_price_i,
  input  logic                 start_of_series_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PRICE_W-1:0]   macd_value_o,
  output logic                 macd_valid_o,
  output logic [PRICE_W-1:0]   signal_value_o,
  output logic                 signal_valid_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [LEN_W-1:0]     cfg_data_i
);

  state_e                    state_q, state_d;
  chan_e                     ch_q, ch_d;
  logic [LEN_W-1:0]          len_reg_q [3];
  logic [2:0]                stale_q;
  logic [CNT_W-1:0]          si_q, mc_q;
  logic signed [ACC_W-1:0]   seed_q [3];
  logic signed [ACC_W-1:0]   avg_q [3];
  logic [ALPHA_W-1:0]        alpha_q [3];
  chan_e                     alpha_sel_q, alpha_sel;
  logic signed [PRICE_W-1:0] x_q, macd_q;
  logic                      neg_q;
  logic                      out_valid_q;
  logic [PRICE_W-1:0]        macd_out_q, sig_out_q;
  logic                      mvalid_out_q, svalid_out_q, macd_ok_q;

  logic                      in_acc, out_free;
  logic [LEN_W-1:0]          len_f, len_s, len_g, len_cur, len_alpha;
  logic [CNT_W-1:0]          cnt_cur;
  logic signed [ACC_W-1:0]   x_cur, seed_new;
  logic signed [ACC_W+1:0]   seed_num;
  logic                      cnt_lt, cnt_eq, mvalid, svalid;
  logic [2:0]                sel_mask;
  logic signed [ACC_W:0]     diff_full, macd_full;
  logic signed [PROD_W:0]    rnd;
  logic signed [ACC_W-1:0]   step;
  logic [DIV_W-1:0]          div_mag, quot_adj;
  logic signed [DIV_W:0]     seed_mean;

  alu_ctrl_t                 alu_ctrl;
  alu_stat_t                 alu_stat;
  logic signed [DIFF_W-1:0]  mul_a;
  logic [ALPHA_W-1:0]        mul_b;
  logic [DIV_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic signed [PROD_W-1:0]  prod;
  logic [DIV_W-1:0]          quot;

  assign len_f = eff_len(len_reg_q[REG_FAST]);
  assign len_s = eff_len(len_reg_q[REG_SLOW]);
  assign len_g = eff_len(len_reg_q[REG_SIGNAL]);

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (ch_q)
      CH_FAST:   len_cur = len_f;
      CH_SLOW:   len_cur = len_s;
      CH_SIGNAL: len_cur = len_g;
      default:   len_cur = len_f;
    endcase
  end

  assign cnt_cur = (ch_q == CH_SIGNAL) ? mc_q : si_q;
  assign x_cur   = (ch_q == CH_SIGNAL) ? ACC_W'(macd_q) : ACC_W'(x_q);
  assign cnt_lt  = cnt_cur < {1'b0, len_cur};
  assign cnt_eq  = cnt_cur == {1'b0, len_cur};
  assign seed_new = seed_q[ch_q] + x_cur;

  // first length whose alpha is out of date
  always_comb begin
    priority if (stale_q[CH_FAST]) begin
      alpha_sel = CH_FAST;
      len_alpha = len_f;
    end else if (stale_q[CH_SLOW]) begin
      alpha_sel = CH_SLOW;
      len_alpha = len_s;
    end else begin
      alpha_sel = CH_SIGNAL;
      len_alpha = len_g;
    end
  end

  assign sel_mask = 3'b001 << alpha_sel_q;

  // seed mean: floor((2*sum + L) / (2*L))
  assign seed_num = {seed_q[ch_q][ACC_W-1], seed_q[ch_q], 1'b0}
                    + (ACC_W+2)'({1'b0, len_cur});
  assign div_mag  = seed_num[ACC_W+1] ? DIV_W'(-seed_num) : DIV_W'(seed_num);
  assign quot_adj = (neg_q && alu_stat.rem_nz) ? quot + DIV_W'(1) : quot;
  assign seed_mean = neg_q ? -$signed({1'b0, quot_adj}) : $signed({1'b0, quot_adj});

  assign diff_full = {x_cur[ACC_W-1], x_cur} - {avg_q[ch_q][ACC_W-1], avg_q[ch_q]};
  assign rnd  = {prod[PROD_W-1], prod} + ((PROD_W+1)'(1) <<< (ALPHA_BITS - 1));
  assign step = ACC_W'(rnd >>> ALPHA_BITS);

  assign macd_full = {avg_q[CH_FAST][ACC_W-1], avg_q[CH_FAST]}
                     - {avg_q[CH_SLOW][ACC_W-1], avg_q[CH_SLOW]};
  assign mvalid = (si_q >= {1'b0, len_f}) && (si_q >= {1'b0, len_s});
  assign svalid = mvalid_out_q && (mc_q >= {1'b0, len_g});

  // next state
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d    = CH_FAST;
          state_d = (stale_q != '0) ? ST_ALPHA : ST_STEP;
        end
      end
      ST_ALPHA: state_d = ST_ALPHA_WAIT;
      ST_ALPHA_WAIT: begin
        if (alu_stat.div_done) begin
          state_d = ((stale_q & ~sel_mask) != '0) ? ST_ALPHA : ST_STEP;
        end
      end
      ST_STEP, ST_SEED_WAIT, ST_UPD: begin
        if ((state_q == ST_STEP && !cnt_lt) && cnt_eq) begin
          state_d = ST_SEED_DIV;
        end else if (state_q == ST_STEP && !cnt_lt) begin
          state_d = ST_UPD;
        end else if (state_q != ST_SEED_WAIT || alu_stat.div_done) begin
          unique case (ch_q)
            CH_FAST: begin
              ch_d    = CH_SLOW;
              state_d = ST_STEP;
            end
            CH_SLOW:   state_d = ST_MACD;
            CH_SIGNAL: state_d = ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SEED_DIV: state_d = ST_SEED_WAIT;
      ST_MACD: begin
        if (mvalid) begin
          ch_d    = CH_SIGNAL;
          state_d = ST_STEP;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o         = state_q != ST_IDLE;
    alu_ctrl.mul_start = (state_q == ST_STEP) && !cnt_lt && !cnt_eq;
    alu_ctrl.div_start = (state_q == ST_ALPHA) || (state_q == ST_SEED_DIV);
    mul_a              = DIFF_W'(diff_full);
    mul_b              = alpha_q[ch_q];
    if (state_q == ST_ALPHA) begin
      // alpha = floor((2^25 + (L+1)/2) / (L+1))
      div_num = (DIV_W'(1) << (ALPHA_BITS + 1))
                + DIV_W'(({1'b0, len_alpha} + DEN_W'(1)) >> 1);
      div_den = {1'b0, len_alpha} + DEN_W'(1);
    end else begin
      div_num = div_mag;
      div_den = {len_cur, 1'b0};
    end
  end

  macd_alu u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (alu_ctrl),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .div_num_i (div_num),
    .div_den_i (div_den),
    .prod_o    (prod),
    .quot_o    (quot),
    .stat_o    (alu_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q              <= ST_IDLE;
      ch_q                 <= CH_FAST;
      len_reg_q[REG_FAST]   <= FAST_RESET;
      len_reg_q[REG_SLOW]   <= SLOW_RESET;
      len_reg_q[REG_SIGNAL] <= SIGNAL_RESET;
      stale_q              <= '1;
      si_q                 <= '0;
      mc_q                 <= '0;
      for (int i = 0; i < 3; i++) begin
        seed_q[i] <= '0;
        avg_q[i]  <= '0;
      end
      out_valid_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_FAST: begin
            len_reg_q[REG_FAST] <= cfg_data_i;
            stale_q[CH_FAST]    <= 1'b1;
          end
          REG_SLOW: begin
            len_reg_q[REG_SLOW] <= cfg_data_i;
            stale_q[CH_SLOW]    <= 1'b1;
          end
          REG_SIGNAL: begin
            len_reg_q[REG_SIGNAL] <= cfg_data_i;
            stale_q[CH_SIGNAL]    <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (start_of_series_i) begin
              si_q <= CNT_W'(1);
              mc_q <= '0;
              for (int i = 0; i < 3; i++) begin
                seed_q[i] <= '0;
                avg_q[i]  <= '0;
              end
            end else if (si_q != CNT_W'(COUNT_TOP)) begin
              si_q <= si_q + CNT_W'(1);
            end
          end
        end
        ST_ALPHA_WAIT: begin
          if (alu_stat.div_done) begin
            stale_q <= stale_q & ~sel_mask;
          end
        end
        ST_STEP: begin
          if (cnt_lt || cnt_eq) begin
            seed_q[ch_q] <= seed_new;
          end
        end
        ST_SEED_WAIT: begin
          if (alu_stat.div_done) begin
            avg_q[ch_q]  <= ACC_W'(seed_mean);
            seed_q[ch_q] <= '0;
          end
        end
        ST_UPD: avg_q[ch_q] <= avg_q[ch_q] + step;
        ST_MACD: begin
          if (mvalid && mc_q != CNT_W'(COUNT_TOP)) begin
            mc_q <= mc_q + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= close_price_i;
    end
    if (state_q == ST_ALPHA) begin
      alpha_sel_q <= alpha_sel;
    end
    if (state_q == ST_ALPHA_WAIT && alu_stat.div_done) begin
      alpha_q[alpha_sel_q] <= quot[ALPHA_W-1:0];
    end
    if (state_q == ST_SEED_DIV) begin
      neg_q <= seed_num[ACC_W+1];
    end
    if (state_q == ST_MACD) begin
      macd_q       <= mvalid ? sat32(macd_full) : '0;
      mvalid_out_q <= mvalid;
    end
    if (state_q == ST_DONE && out_free) begin
      macd_out_q   <= macd_q;
      macd_ok_q    <= mvalid_out_q;
      sig_out_q    <= svalid ? sat32({avg_q[CH_SIGNAL][ACC_W-1], avg_q[CH_SIGNAL]}) : '0;
      svalid_out_q <= svalid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign macd_value_o   = macd_out_q;
  assign macd_valid_o   = macd_ok_q;
  assign signal_value_o = sig_out_q;
  assign signal_valid_o = svalid_out_q;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking testbench of macd_ema_filter, random and directed price series
// a scoreboard class predicts macd and signal per item; depends on macd_pkg and the rtl
module tb_top;
  import macd_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic [PRICE_W-1:0] macd;
    logic               macd_ok;
    logic [PRICE_W-1:0] sig;
    logic               sig_ok;
  } macd_result_t;

  class macd_scoreboard;
    logic [LEN_W-1:0] length_reg [3];
    longint           n_prices;
    longint           n_macd;
    longint           seed_sum [3];
    longint           average [3];
    macd_result_t     due_q [$];
    int unsigned      mismatches;

    function new();
      length_reg[CH_FAST]   = FAST_RESET;
      length_reg[CH_SLOW]   = SLOW_RESET;
      length_reg[CH_SIGNAL] = SIGNAL_RESET;
      mismatches = 0;
      clear_series();
    endfunction

    function void clear_series();
      n_prices = 0;
      n_macd   = 0;
      for (int c = 0; c < 3; c++) begin
        seed_sum[c] = 0;
        average[c]  = 0;
      end
    endfunction

    function void set_length(cfg_reg_e idx, logic [LEN_W-1:0] v);
      length_reg[idx] = v;
    endfunction

    function longint clamp_len(logic [LEN_W-1:0] r);
      longint l;
      l = longint'(r);
      if (l == 0) l = 1;
      if (l > MAX_LENGTH) l = MAX_LENGTH;
      return l;
    endfunction

    function longint sat_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // seed with the rounded mean, then step by alpha in q1.24
    function void ema_advance(int c, longint x, longint cnt, longint len);
      longint num, den, q, alpha, prod;
      if (cnt < len) begin
        seed_sum[c] += x;
      end else if (cnt == len) begin
        seed_sum[c] += x;
        num = 2 * seed_sum[c] + len;
        den = 2 * len;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        average[c]  = q;
        seed_sum[c] = 0;
      end else begin
        alpha = ((longint'(1) <<< (ALPHA_BITS + 1)) + (len + 1) / 2) / (len + 1);
        prod  = (x - average[c]) * alpha + (longint'(1) <<< (ALPHA_BITS - 1));
        average[c] += prod >>> ALPHA_BITS;
      end
    endfunction

    function void note_item(logic [PRICE_W-1:0] price, logic sos);
      macd_result_t r;
      longint x, lf, ls, lg, m;
      x  = longint'($signed(price));
      lf = clamp_len(length_reg[CH_FAST]);
      ls = clamp_len(length_reg[CH_SLOW]);
      lg = clamp_len(length_reg[CH_SIGNAL]);
      if (sos) clear_series();
      if (n_prices < COUNT_TOP) n_prices++;
      ema_advance(CH_FAST, x, n_prices, lf);
      ema_advance(CH_SLOW, x, n_prices, ls);
      r.macd    = '0;
      r.sig     = '0;
      r.sig_ok  = 1'b0;
      r.macd_ok = (n_prices >= lf) && (n_prices >= ls);
      if (r.macd_ok) begin
        m = sat_word(average[CH_FAST] - average[CH_SLOW]);
        r.macd = m[PRICE_W-1:0];
        if (n_macd < COUNT_TOP) n_macd++;
        ema_advance(CH_SIGNAL, m, n_macd, lg);
        r.sig_ok = n_macd >= lg;
        if (r.sig_ok) begin
          m = sat_word(average[CH_SIGNAL]);
          r.sig = m[PRICE_W-1:0];
        end
      end
      due_q.push_back(r);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void check_result(logic [PRICE_W-1:0] mv, logic mok, logic [PRICE_W-1:0] sv,
                               logic sok);
      macd_result_t e;
      if (due_q.size() == 0) begin
        report("result arrived with no item pending");
        return;
      end
      e = due_q.pop_front();
      if (mv !== e.macd) report($sformatf("macd_value %h, want %h", mv, e.macd));
      if (mok !== e.macd_ok) report($sformatf("macd_valid %b, want %b", mok, e.macd_ok));
      if (sv !== e.sig) report($sformatf("signal_value %h, want %h", sv, e.sig));
      if (sok !== e.sig_ok) report($sformatf("signal_valid %b, want %b", sok, e.sig_ok));
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [PRICE_W-1:0]   close_price_i;
  logic                 start_of_series_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [PRICE_W-1:0]   macd_value_o;
  logic                 macd_valid_o;
  logic [PRICE_W-1:0]   signal_value_o;
  logic                 signal_valid_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [LEN_W-1:0]     cfg_data_i;

  macd_scoreboard     sb;
  bit                 calm;
  int                 idle_cycles;
  logic [PRICE_W-1:0] last_price;

  macd_ema_filter u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .close_price_i     (close_price_i),
    .start_of_series_i (start_of_series_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .macd_value_o      (macd_value_o),
    .macd_valid_o      (macd_valid_o),
    .signal_value_o    (signal_value_o),
    .signal_valid_o    (signal_valid_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // result side: check, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(macd_value_o, macd_valid_o, signal_value_o, signal_valid_o);
    end
    out_stall_i <= !calm && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("macd_ema_filter verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [PRICE_W-1:0] price, input logic sos);
    if (!calm) begin
      while ($urandom_range(0, 99) < 13) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i        <= 1'b1;
    close_price_i     <= price;
    start_of_series_i <= sos;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(price, sos);
  endtask

  // hold the sender until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] s,
                               input logic [LEN_W-1:0] g);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FAST;
    cfg_data_i  <= f;
    @(posedge clk_i);
    cfg_index_i <= REG_SLOW;
    cfg_data_i  <= s;
    @(posedge clk_i);
    cfg_index_i <= REG_SIGNAL;
    cfg_data_i  <= g;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_length(REG_FAST, f);
    sb.set_length(REG_SLOW, s);
    sb.set_length(REG_SIGNAL, g);
  endtask

  function automatic logic [PRICE_W-1:0] next_price(int mode, logic [PRICE_W-1:0] prev);
    logic [PRICE_W-1:0] step;
    case (mode)
      0: begin
        return $urandom();
      end
      1: begin
        step = $urandom_range(0, 2097152);
        return prev + step - 32'd1048576;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return $urandom();
        endcase
      end
    endcase
  endfunction

  task automatic run_directed();
    logic [PRICE_W:0] first_q [$];
    logic [PRICE_W:0] second_q [$];
    logic [PRICE_W:0] third_q [$];
    // series without a start flag straight after reset, at reset lengths
    first_q  = '{{1'b0, 32'h7fff_ffff}, {1'b0, 32'h8000_0000}, {1'b1, 32'h0000_0000}};
    second_q = '{{1'b1, 32'h7fff_ffff}, {1'b0, 32'h8000_0000}, {1'b0, 32'h7fff_ffff},
                 {1'b0, 32'h8000_0000}, {1'b0, 32'h7fff_ffff}, {1'b0, 32'h7fff_ffff},
                 {1'b0, 32'h8000_0000}, {1'b0, 32'h8000_0000}, {1'b0, 32'h0000_0000},
                 {1'b0, 32'hffff_ffff}, {1'b0, 32'h0000_0001}, {1'b0, 32'h0001_0000},
                 {1'b1, 32'hfffe_0000}, {1'b0, 32'h7fff_ffff}, {1'b0, 32'h8000_0000},
                 {1'b0, 32'h1234_5678}, {1'b0, 32'hedcb_a987}};
    third_q  = '{{1'b1, 32'h7fff_ffff}, {1'b0, 32'h8000_0000}, {1'b0, 32'h7fff_ffff},
                 {1'b0, 32'h8000_0000}, {1'b0, 32'h5555_aaaa}};
    foreach (first_q[i]) send_item(first_q[i][PRICE_W-1:0], first_q[i][PRICE_W]);
    settle();
    // zero fast length acts as one
    write_lengths(8'd0, 8'd2, 8'd1);
    foreach (second_q[i]) send_item(second_q[i][PRICE_W-1:0], second_q[i][PRICE_W]);
    settle();
    write_lengths(8'd3, 8'd1, 8'd2);
    foreach (third_q[i]) send_item(third_q[i][PRICE_W-1:0], third_q[i][PRICE_W]);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] f, input logic [LEN_W-1:0] s,
                           input logic [LEN_W-1:0] g, input int n_items, input int smin,
                           input int smax, input int noise_pct, input int calm_items,
                           input bit fresh);
    int   left;
    int   mode;
    logic sos;
    left = 0;
    mode = $urandom_range(0, 2);
    settle();
    write_lengths(f, s, g);
    // carry on the old series under new lengths
    if (!fresh) left = $urandom_range(smin, smax);
    for (int i = 0; i < n_items; i++) begin
      calm = (i < calm_items);
      sos  = 1'b0;
      if (left == 0) begin
        left = $urandom_range(smin, smax);
        mode = $urandom_range(0, 2);
        sos  = 1'b1;
      end else if ($urandom_range(0, 99) < noise_pct) begin
        sos = 1'b1;
      end
      left--;
      last_price = next_price(mode, last_price);
      if (i == n_items / 2) settle();
      send_item(last_price, sos);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    close_price_i     = '0;
    start_of_series_i = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = REG_FAST;
    cfg_data_i        = '0;
    calm              = 1'b0;
    last_price        = '0;
    sb                = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_phase(LEN_W'($urandom_range(1, 10)), LEN_W'($urandom_range(1, 24)),
              LEN_W'($urandom_range(1, 10)), 140, 15, 60, 0, 0, 1'b1);
    run_phase(LEN_W'($urandom_range(0, 12)), LEN_W'($urandom_range(0, 30)),
              LEN_W'($urandom_range(0, 12)), 60, 30, 80, 3, 0, 1'b0);
    run_phase(8'd0, 8'd0, 8'd0, 30, 5, 15, 0, 0, 1'b1);
    // longest lengths, one series long enough to saturate the price counter
    run_phase(8'd255, 8'd255, 8'd255, 540, 540, 540, 0, 200, 1'b1);
    run_phase(LEN_W'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 40)),
              LEN_W'($urandom_range(0, 20)), 100, 10, 60, 5, 0, 1'b1);
    run_phase(LEN_W'($urandom_range(1, 5)), LEN_W'($urandom_range(1, 5)),
              LEN_W'($urandom_range(1, 5)), 40, 5, 20, 10, 0, 1'b1);

    settle();
    repeat (48) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("macd_ema_filter verification clean");
    end else begin
      $display("macd_ema_filter verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/macd_pkg.sv
src/macd_alu.sv
src/macd_ema_filter.sv
tb/tb_top.sv
